[sv/cpu_instruction_subset_execute_unit_defines.svh]
// Assertion macros shared by the checker of the instruction execute unit.
`ifndef CPU_INSTRUCTION_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define CPU_INSTRUCTION_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CISE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cise check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CISE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cise check failed");

`endif

[sv/cise_pkg.sv]
// Types and opcode constants of the instruction execute unit.
package cise_pkg;

	localparam logic [7:0] OP_NOP     = 8'h00;
	localparam logic [7:0] OP_LD_BC   = 8'h01;
	localparam logic [7:0] OP_ST_BC_A = 8'h02;
	localparam logic [7:0] OP_INC_BC  = 8'h03;
	localparam logic [7:0] OP_INC_B   = 8'h04;
	localparam logic [7:0] OP_DEC_B   = 8'h05;
	localparam logic [7:0] OP_LD_B    = 8'h06;
	localparam logic [7:0] OP_RLCA    = 8'h07;
	localparam logic [7:0] OP_LD_SP   = 8'h08;
	localparam logic [7:0] OP_ADD_HL  = 8'h09;

	typedef struct packed {
		logic [7:0] op_byte;
		logic [7:0] imm_low;
		logic [7:0] imm_high;
	} in_item_t;

	// Flags are ordered Z, N, H, C from bit 3 down to bit 0.
	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [3:0]  znhc;
		logic [15:0] sp;
		logic [15:0] pc;
	} arch_state_t;

	typedef struct packed {
		logic [7:0]  reg_a;
		logic [7:0]  reg_b;
		logic [7:0]  reg_c;
		logic [7:0]  reg_h;
		logic [7:0]  reg_l;
		logic [7:0]  flag_bits;
		logic [15:0] stack_ptr;
		logic [15:0] prog_ctr;
		logic        mem_write;
		logic [15:0] mem_addr;
		logic [7:0]  mem_data;
		logic [1:0]  cycle_cost;
	} result_t;

endpackage

[sv/cise_if.sv]
// Valid/ready channel interfaces for instruction words and result words.
interface cise_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] op_byte;
	logic [7:0] imm_low;
	logic [7:0] imm_high;

	modport source(output valid, output op_byte, output imm_low, output imm_high,
		input ready);
	modport sink(input valid, input op_byte, input imm_low, input imm_high,
		output ready);
endinterface

interface cise_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reg_a;
	logic [7:0]  reg_b;
	logic [7:0]  reg_c;
	logic [7:0]  reg_h;
	logic [7:0]  reg_l;
	logic [7:0]  flag_bits;
	logic [15:0] stack_ptr;
	logic [15:0] prog_ctr;
	logic        mem_write;
	logic [15:0] mem_addr;
	logic [7:0]  mem_data;
	logic [1:0]  cycle_cost;

	modport source(output valid, output reg_a, output reg_b, output reg_c,
		output reg_h, output reg_l, output flag_bits, output stack_ptr,
		output prog_ctr, output mem_write, output mem_addr, output mem_data,
		output cycle_cost, input ready);
	modport sink(input valid, input reg_a, input reg_b, input reg_c,
		input reg_h, input reg_l, input flag_bits, input stack_ptr,
		input prog_ctr, input mem_write, input mem_addr, input mem_data,
		input cycle_cost, output ready);
endinterface

[sv/cise_alu.sv]
// Combinational execute logic: next register state and result word for one instruction.
module cise_alu (
	input  cise_pkg::in_item_t    item,
	input  cise_pkg::arch_state_t cur,
	output cise_pkg::arch_state_t nxt,
	output cise_pkg::result_t     res
);

	logic [15:0] bc;
	logic [15:0] hl;
	logic [16:0] hl_sum;
	logic [12:0] hl_half;
	logic [7:0]  b_inc;
	logic [7:0]  b_dec;
	logic [1:0]  len;
	logic [1:0]  cost;
	logic        wr;

	assign bc      = {cur.b, cur.c};
	assign hl      = {cur.h, cur.l};
	assign hl_sum  = {1'b0, hl} + {1'b0, bc};
	assign hl_half = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};
	assign b_inc   = cur.b + 8'd1;
	assign b_dec   = cur.b - 8'd1;

	always_comb begin
		nxt  = cur;
		len  = 2'd1;
		cost = 2'd1;
		wr   = 1'b0;
		unique case (item.op_byte)
			cise_pkg::OP_LD_BC: begin
				nxt.c = item.imm_low;
				nxt.b = item.imm_high;
				len   = 2'd3;
				cost  = 2'd3;
			end
			cise_pkg::OP_ST_BC_A: begin
				wr   = 1'b1;
				cost = 2'd2;
			end
			cise_pkg::OP_INC_BC: begin
				{nxt.b, nxt.c} = bc + 16'd1;
				cost           = 2'd2;
			end
			cise_pkg::OP_INC_B: begin
				nxt.b    = b_inc;
				nxt.znhc = {b_inc == 8'd0, 1'b0, cur.b[3:0] == 4'hF, cur.znhc[0]};
			end
			cise_pkg::OP_DEC_B: begin
				nxt.b    = b_dec;
				nxt.znhc = {b_dec == 8'd0, 1'b1, cur.b[3:0] == 4'h0, cur.znhc[0]};
			end
			cise_pkg::OP_LD_B: begin
				nxt.b = item.imm_low;
				len   = 2'd2;
				cost  = 2'd2;
			end
			cise_pkg::OP_RLCA: begin
				nxt.a    = {cur.a[6:0], cur.a[7]};
				nxt.znhc = {3'b000, cur.a[7]};
			end
			cise_pkg::OP_LD_SP: begin
				nxt.sp = {item.imm_high, item.imm_low};
				len    = 2'd3;
				cost   = 2'd3;
			end
			cise_pkg::OP_ADD_HL: begin
				{nxt.h, nxt.l} = hl_sum[15:0];
				nxt.znhc       = {cur.znhc[3], 1'b0, hl_half[12], hl_sum[16]};
				cost           = 2'd2;
			end
			default: begin
			end
		endcase
		nxt.pc = cur.pc + {14'd0, len};
	end

	always_comb begin
		res.reg_a      = nxt.a;
		res.reg_b      = nxt.b;
		res.reg_c      = nxt.c;
		res.reg_h      = nxt.h;
		res.reg_l      = nxt.l;
		res.flag_bits  = {nxt.znhc, 4'h0};
		res.stack_ptr  = nxt.sp;
		res.prog_ctr   = nxt.pc;
		res.mem_write  = wr;
		res.mem_addr   = wr ? bc : 16'h0000;
		res.mem_data   = wr ? cur.a : 8'h00;
		res.cycle_cost = cost;
	end

endmodule

[sv/cpu_instruction_subset_execute_unit.sv]
// Top level of the instruction execute unit: input register, execute logic, result register.
//
// Instruction words arrive on in_ch: an opcode byte and the two bytes that follow it.
// Each accepted word produces exactly one result word on out_ch, carrying the register
// file, flags, SP and PC after the instruction, any store of A at address BC, and the
// machine-cycle cost of the instruction.
// An accepted word waits in the input register; the execute logic then writes the result
// register and the register file at the same edge.
// Throughput is one word per cycle while out_ch does not stall. The input register
// advances whenever the result register is empty or is being read, so in_ch stays ready
// while out_ch takes words. When out_ch stalls, the result holds, the input register
// keeps one more word, and in_ch then drops ready until out_ch takes the pending result.
// Reset clears both stage valid bits and sets A, B, C, H, L, the flags, SP and PC to
// zero.
module cpu_instruction_subset_execute_unit (
	input logic        clk,
	input logic        arst_n,
	cise_in_if.sink    in_ch,
	cise_out_if.source out_ch
);

	cise_pkg::in_item_t    item_s1;
	logic                  valid_s1;
	cise_pkg::result_t     res_s2;
	logic                  valid_s2;
	cise_pkg::arch_state_t arch_q;
	cise_pkg::arch_state_t arch_nxt;
	cise_pkg::result_t     res_nxt;
	logic                  adv_s1;
	logic                  take_in;

	assign adv_s1      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;
	assign take_in     = in_ch.valid && in_ch.ready;

	cise_alu u_alu (
		.item(item_s1),
		.cur (arch_q),
		.nxt (arch_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{op_byte: in_ch.op_byte, imm_low: in_ch.imm_low,
				imm_high: in_ch.imm_high};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			arch_q   <= '0;
		end else begin
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				arch_q   <= arch_nxt;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.reg_a      = res_s2.reg_a;
	assign out_ch.reg_b      = res_s2.reg_b;
	assign out_ch.reg_c      = res_s2.reg_c;
	assign out_ch.reg_h      = res_s2.reg_h;
	assign out_ch.reg_l      = res_s2.reg_l;
	assign out_ch.flag_bits  = res_s2.flag_bits;
	assign out_ch.stack_ptr  = res_s2.stack_ptr;
	assign out_ch.prog_ctr   = res_s2.prog_ctr;
	assign out_ch.mem_write  = res_s2.mem_write;
	assign out_ch.mem_addr   = res_s2.mem_addr;
	assign out_ch.mem_data   = res_s2.mem_data;
	assign out_ch.cycle_cost = res_s2.cycle_cost;

endmodule

[sv/cise_checker.sv]
// Port-level assertion checker for the instruction execute unit, with its bind statement.
`include "cpu_instruction_subset_execute_unit_defines.svh"

module cise_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  flag_bits,
	input logic [15:0] prog_ctr,
	input logic        mem_write,
	input logic [15:0] mem_addr,
	input logic [7:0]  mem_data,
	input logic [1:0]  cycle_cost
);

	// A stalled result word keeps its valid and its program counter.
	`CISE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(prog_ctr))

	// Without a store, the store address and data read as zero.
	`CISE_ASSERT_NOW(a_no_store_zero, out_valid && !mem_write,
		mem_addr == 16'h0000 && mem_data == 8'h00)

	// Every instruction costs one to three machine cycles and never sets the low flag nibble.
	`CISE_ASSERT_NOW(a_cost_flags, out_valid, cycle_cost != 2'd0 && flag_bits[3:0] == 4'h0)

	// With the result register full and stalled, accepting a word keeps the result valid.
	`CISE_ASSERT_NEXT(a_back_pressure, in_valid && in_ready && out_valid && !out_ready,
		!out_ready || !in_ready || out_valid)

endmodule

bind cpu_instruction_subset_execute_unit cise_checker u_cise_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.flag_bits (out_ch.flag_bits),
	.prog_ctr  (out_ch.prog_ctr),
	.mem_write (out_ch.mem_write),
	.mem_addr  (out_ch.mem_addr),
	.mem_data  (out_ch.mem_data),
	.cycle_cost(out_ch.cycle_cost)
);

[sim/cpu_instruction_subset_execute_unit_tb.sv]
// Self-checking testbench of the instruction execute unit with its own prediction of each result word.
`timescale 1ns / 1ps

module cpu_instruction_subset_execute_unit_tb;

	localparam int HOLD_CYCLES = 300;
	localparam int WD_LIMIT    = 4000;
	localparam int MAX_REPORTS = 60;

	logic clk;
	logic arst_n;

	cise_in_if  in_ch();
	cise_out_if out_ch();

	cpu_instruction_subset_execute_unit DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	cise_pkg::arch_state_t core_st;
	cise_pkg::result_t     pending_results[$];
	int                    errors;
	int                    burst_left;
	bit                    no_gaps;
	bit                    hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Executes one instruction word on the testbench copy of the core.
	task automatic execute_model(input cise_pkg::in_item_t w, output cise_pkg::result_t r);
		logic [7:0]  old;
		logic [15:0] hl;
		logic [15:0] bc;
		logic [16:0] sum;
		logic [12:0] half;
		logic [15:0] len;
		logic [1:0]  cost;
		logic [3:0]  f;
		r = '0;
		len = 16'd1;
		cost = 2'd1;
		f = core_st.znhc;
		old = core_st.b;
		case (w.op_byte)
			cise_pkg::OP_LD_BC: begin
				core_st.c = w.imm_low;
				core_st.b = w.imm_high;
				len = 16'd3;
				cost = 2'd3;
			end
			cise_pkg::OP_ST_BC_A: begin
				r.mem_write = 1'b1;
				r.mem_addr = {core_st.b, core_st.c};
				r.mem_data = core_st.a;
				cost = 2'd2;
			end
			cise_pkg::OP_INC_BC: begin
				{core_st.b, core_st.c} = {core_st.b, core_st.c} + 16'd1;
				cost = 2'd2;
			end
			cise_pkg::OP_INC_B: begin
				core_st.b = old + 8'd1;
				f = {core_st.b == 8'h00, 1'b0, old[3:0] == 4'hF, f[0]};
			end
			cise_pkg::OP_DEC_B: begin
				core_st.b = old - 8'd1;
				f = {core_st.b == 8'h00, 1'b1, old[3:0] == 4'h0, f[0]};
			end
			cise_pkg::OP_LD_B: begin
				core_st.b = w.imm_low;
				len = 16'd2;
				cost = 2'd2;
			end
			cise_pkg::OP_RLCA: begin
				f = {3'b000, core_st.a[7]};
				core_st.a = {core_st.a[6:0], core_st.a[7]};
			end
			cise_pkg::OP_LD_SP: begin
				core_st.sp = {w.imm_high, w.imm_low};
				len = 16'd3;
				cost = 2'd3;
			end
			cise_pkg::OP_ADD_HL: begin
				hl = {core_st.h, core_st.l};
				bc = {core_st.b, core_st.c};
				sum = {1'b0, hl} + {1'b0, bc};
				half = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};
				f = {f[3], 1'b0, half[12], sum[16]};
				{core_st.h, core_st.l} = sum[15:0];
				cost = 2'd2;
			end
			default: begin
			end
		endcase
		core_st.znhc = f;
		core_st.pc = core_st.pc + len;
		r.reg_a = core_st.a;
		r.reg_b = core_st.b;
		r.reg_c = core_st.c;
		r.reg_h = core_st.h;
		r.reg_l = core_st.l;
		r.flag_bits = {core_st.znhc, 4'h0};
		r.stack_ptr = core_st.sp;
		r.prog_ctr = core_st.pc;
		r.cycle_cost = cost;
	endtask

	task automatic send_word(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
		cise_pkg::in_item_t w;
		cise_pkg::result_t  r;
		w = {op, lo, hi};
		in_ch.valid <= 1'b1;
		in_ch.op_byte <= op;
		in_ch.imm_low <= lo;
		in_ch.imm_high <= hi;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		execute_model(w, r);
		pending_results.push_back(r);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			if (!no_gaps) begin
				gap = $urandom_range(1, 6);
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random();
		logic [7:0] op;
		if ($urandom_range(0, 4) != 0)
			op = 8'($urandom_range(0, 9));
		else
			op = 8'($urandom_range(0, 255));
		send_word(op, rand_byte(), rand_byte());
		pace();
	endtask

	task automatic send_paced(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
		send_word(op, lo, hi);
		pace();
	endtask

	task automatic test_directed();
		send_paced(cise_pkg::OP_NOP, 8'hFF, 8'hFF);
		send_paced(cise_pkg::OP_DEC_B, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_INC_B, 8'hFF, 8'h00);
		send_paced(cise_pkg::OP_LD_B, 8'h0F, 8'hFF);
		send_paced(cise_pkg::OP_INC_B, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_DEC_B, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_LD_B, 8'h01, 8'h00);
		send_paced(cise_pkg::OP_DEC_B, 8'hFF, 8'hFF);
		send_paced(cise_pkg::OP_LD_BC, 8'hFF, 8'hFF);
		send_paced(cise_pkg::OP_ADD_HL, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_ADD_HL, 8'hFF, 8'hFF);
		send_paced(cise_pkg::OP_ST_BC_A, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_INC_BC, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_ST_BC_A, 8'hFF, 8'hFF);
		send_paced(cise_pkg::OP_RLCA, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_LD_SP, 8'hFF, 8'hFF);
		send_paced(cise_pkg::OP_LD_SP, 8'h00, 8'h00);
		send_paced(cise_pkg::OP_LD_BC, 8'h00, 8'h80);
		send_paced(cise_pkg::OP_LD_BC, 8'hFF, 8'h0F);
		send_paced(cise_pkg::OP_ADD_HL, 8'h00, 8'h00);
		send_paced(8'h0A, 8'hFF, 8'hFF);
		send_paced(8'hFF, 8'h00, 8'h00);
		send_paced(8'h10, 8'hA5, 8'h5A);
		send_paced(8'h80, 8'h5A, 8'hA5);
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < 1300; i++) begin
			no_gaps = (i >= 600 && i < 700);
			send_random();
		end
		no_gaps = 1'b0;
		wait_drained();
	endtask

	// The receiver holds off while words keep coming, so the block fills and stalls its input.
	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_random();
		no_gaps = 1'b0;
		wait_drained();
	endtask

	task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
		if (act !== exp) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s expected %h, got %h", $time, name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cise_pkg::result_t e;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: unexpected result word, expected none, got pc %h",
						$time, out_ch.prog_ctr);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("reg_a", 16'(e.reg_a), 16'(out_ch.reg_a));
				check_field("reg_b", 16'(e.reg_b), 16'(out_ch.reg_b));
				check_field("reg_c", 16'(e.reg_c), 16'(out_ch.reg_c));
				check_field("reg_h", 16'(e.reg_h), 16'(out_ch.reg_h));
				check_field("reg_l", 16'(e.reg_l), 16'(out_ch.reg_l));
				check_field("flag_bits", 16'(e.flag_bits), 16'(out_ch.flag_bits));
				check_field("stack_ptr", e.stack_ptr, out_ch.stack_ptr);
				check_field("prog_ctr", e.prog_ctr, out_ch.prog_ctr);
				check_field("mem_write", 16'(e.mem_write), 16'(out_ch.mem_write));
				check_field("mem_addr", e.mem_addr, out_ch.mem_addr);
				check_field("mem_data", 16'(e.mem_data), 16'(out_ch.mem_data));
				check_field("cycle_cost", 16'(e.cycle_cost), 16'(out_ch.cycle_cost));
			end
		end
	end

	initial begin : rx_pattern
		int   run;
		logic level;
		out_ch.ready = 1'b0;
		run = 0;
		level = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				level = 1'b1;
				run = $urandom_range(1, 20);
				out_ch.ready <= 1'b1;
			end else begin
				if (run == 0) begin
					level = ~level;
					if (level)
						run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 12);
					else
						run = $urandom_range(1, 5);
				end
				out_ch.ready <= level;
				run--;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WD_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid & in_ch.ready) === 1'b1 || (out_ch.valid & out_ch.ready) === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op_byte = 8'h00;
		in_ch.imm_low = 8'h00;
		in_ch.imm_high = 8'h00;
		core_st = '0;
		errors = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (6) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/cise_pkg.sv
sv/cise_if.sv
sv/cise_alu.sv
sv/cpu_instruction_subset_execute_unit.sv
sv/cise_checker.sv
sim/cpu_instruction_subset_execute_unit_tb.sv
